@@ design/cpp_pkg.sv @@
package cpp_pkg;

  localparam int WorldW  = 20;
  localparam int EntW    = 18;
  localparam int ProdW   = EntW + WorldW;
  localparam int CamW    = 40;
  localparam int MagW    = 39;
  localparam int FracW   = 16;
  localparam int NumW    = 56;
  localparam int QW      = 20;
  localparam int NormW   = QW + 1;
  localparam int RcW     = 32;
  localparam int DistW   = 38;
  localparam int PixW    = 24;
  localparam int RotW    = 3 * EntW;
  localparam int TransW  = 3 * WorldW;
  localparam int CoefW   = 12;
  localparam int DistCfgW = 5 * CoefW;
  localparam int IntrW   = 20;
  localparam int FocalW  = 2 * IntrW;
  localparam int PrincW  = 3 * IntrW;
  localparam int CfgW    = 60;
  localparam int CfgIdxW = 3;

  localparam logic [RotW-1:0]   ROT_X_RST = RotW'(65536);
  localparam logic [RotW-1:0]   ROT_Y_RST = RotW'(65536) << EntW;
  localparam logic [RotW-1:0]   ROT_Z_RST = RotW'(65536) << (2 * EntW);
  localparam logic [FocalW-1:0] FOCAL_RST = (FocalW'(64) << IntrW) | FocalW'(64);

  localparam logic signed [NormW-1:0] NORM_LIM = NormW'((1 << QW) - 1);
  localparam logic signed [RcW-1:0]   RC_LIM   = RcW'(32'h7fff_ffff);
  localparam logic signed [PixW-1:0]  PIX_MAX  = PixW'((1 << (PixW - 1)) - 1);
  localparam logic signed [PixW-1:0]  PIX_MIN  = PixW'(1 << (PixW - 1));

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROT_X,
    REG_ROT_Y,
    REG_ROT_Z,
    REG_TRANS,
    REG_DIST,
    REG_FOCAL,
    REG_PRINC
  } cfg_reg_t;

  typedef struct packed {
    logic signed [WorldW-1:0] world_z;
    logic signed [WorldW-1:0] world_y;
    logic signed [WorldW-1:0] world_x;
  } world_t;

  typedef struct packed {
    logic signed [PixW-1:0] image_u;
    logic signed [PixW-1:0] image_v;
    logic                   depth_zero;
    logic                   clipped;
  } pixel_t;

  typedef struct packed {
    logic zero;
    logic clip;
  } side_t;

  typedef struct packed {
    logic [RotW-1:0]     rot_x;
    logic [RotW-1:0]     rot_y;
    logic [RotW-1:0]     rot_z;
    logic [TransW-1:0]   trans;
    logic [DistCfgW-1:0] lens;
    logic [FocalW-1:0]   focal;
    logic [PrincW-1:0]   princ;
  } cfg_t;

endpackage

@@ design/cpp_if.sv @@
interface cpp_point_if;
  logic valid;
  logic ready;
  cpp_pkg::world_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cpp_pixel_if;
  logic valid;
  logic ready;
  cpp_pkg::pixel_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/cpp_transform.sv @@
module cpp_transform (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  cpp_pkg::world_t                pt,
  input  cpp_pkg::cfg_t                  cfg,
  output logic                           out_valid,
  output logic signed [cpp_pkg::CamW-1:0] xc,
  output logic signed [cpp_pkg::CamW-1:0] yc,
  output logic signed [cpp_pkg::CamW-1:0] zc
);
  import cpp_pkg::*;

  logic signed [EntW-1:0]   ent  [3][3];
  logic signed [WorldW-1:0] crd  [3];
  logic signed [WorldW-1:0] tr   [3];
  logic signed [ProdW-1:0]  prod [3][3];
  logic signed [CamW-1:0]   cam  [3];
  logic                     v1;

  always_comb begin
    crd[0] = pt.world_x;
    crd[1] = pt.world_y;
    crd[2] = pt.world_z;
    for (int c = 0; c < 3; c++) begin
      ent[0][c] = cfg.rot_x[c*EntW +: EntW];
      ent[1][c] = cfg.rot_y[c*EntW +: EntW];
      ent[2][c] = cfg.rot_z[c*EntW +: EntW];
      tr[c]     = cfg.trans[c*WorldW +: WorldW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= ent[r][c] * crd[c];
        end
        cam[r] <= CamW'(prod[r][0]) + CamW'(prod[r][1]) + CamW'(prod[r][2]) +
                  CamW'($signed({tr[r], {FracW{1'b0}}}));
      end
    end
  end

  assign xc = cam[0];
  assign yc = cam[1];
  assign zc = cam[2];

endmodule

@@ design/cpp_norm_div.sv @@
module cpp_norm_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [cpp_pkg::CamW-1:0]  xc,
  input  logic signed [cpp_pkg::CamW-1:0]  yc,
  input  logic signed [cpp_pkg::CamW-1:0]  zc,
  output logic                             out_valid,
  output logic signed [cpp_pkg::NormW-1:0] xn,
  output logic signed [cpp_pkg::NormW-1:0] yn,
  output cpp_pkg::side_t                   side
);
  import cpp_pkg::*;

  localparam int DivW = MagW + QW - 1;
  localparam int OvfW = MagW + QW;

  logic [CamW-1:0] ax, ay, az;

  logic [NumW-1:0] p_num_x, p_num_y;
  logic [MagW-1:0] p_nd;
  logic            p_neg_x, p_neg_y, p_zero, p_v;

  logic [NumW-1:0] rem_x [QW+1];
  logic [NumW-1:0] rem_y [QW+1];
  logic [QW-1:0]   q_x   [QW+1];
  logic [QW-1:0]   q_y   [QW+1];
  logic [MagW-1:0] nd    [QW+1];
  logic            neg_x [QW+1];
  logic            neg_y [QW+1];
  logic            ovf_x [QW+1];
  logic            ovf_y [QW+1];
  logic            zero  [QW+1];
  logic            vld   [QW+1];

  logic signed [NormW-1:0] mag_x, mag_y;

  always_comb begin
    ax = xc[CamW-1] ? CamW'(-xc) : CamW'(xc);
    ay = yc[CamW-1] ? CamW'(-yc) : CamW'(yc);
    az = zc[CamW-1] ? CamW'(-zc) : CamW'(zc);
  end

  // prep: magnitudes, rounding offset of half the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num_x <= NumW'({ax[MagW-1:0], {FracW{1'b0}}}) + NumW'(az[MagW-1:1]);
      p_num_y <= NumW'({ay[MagW-1:0], {FracW{1'b0}}}) + NumW'(az[MagW-1:1]);
      p_nd    <= az[MagW-1:0];
      p_neg_x <= xc[CamW-1] ^ zc[CamW-1];
      p_neg_y <= yc[CamW-1] ^ zc[CamW-1];
      p_zero  <= (zc == '0);
    end
  end

  // quotient of 2^QW or more saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x[0] <= p_num_x;
      rem_y[0] <= p_num_y;
      ovf_x[0] <= OvfW'(p_num_x) >= {p_nd, {QW{1'b0}}};
      ovf_y[0] <= OvfW'(p_num_y) >= {p_nd, {QW{1'b0}}};
      q_x[0]   <= '0;
      q_y[0]   <= '0;
      nd[0]    <= p_nd;
      neg_x[0] <= p_neg_x;
      neg_y[0] <= p_neg_y;
      zero[0]  <= p_zero;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar s = 0; s < QW; s++) begin : g_step
    localparam int K = QW - 1 - s;
    logic [DivW-1:0] trial, dx, dy;
    logic            gx, gy;

    assign trial = DivW'(nd[s]) << K;
    assign gx    = DivW'(rem_x[s]) >= trial;
    assign gy    = DivW'(rem_y[s]) >= trial;
    assign dx    = DivW'(rem_x[s]) - trial;
    assign dy    = DivW'(rem_y[s]) - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_x[s+1] <= gx ? NumW'(dx) : rem_x[s];
        rem_y[s+1] <= gy ? NumW'(dy) : rem_y[s];
        q_x[s+1]   <= q_x[s] | (QW'(gx) << K);
        q_y[s+1]   <= q_y[s] | (QW'(gy) << K);
        nd[s+1]    <= nd[s];
        neg_x[s+1] <= neg_x[s];
        neg_y[s+1] <= neg_y[s];
        ovf_x[s+1] <= ovf_x[s];
        ovf_y[s+1] <= ovf_y[s];
        zero[s+1]  <= zero[s];
      end
    end
  end

  always_comb begin
    mag_x = ovf_x[QW] ? NORM_LIM : $signed({1'b0, q_x[QW]});
    mag_y = ovf_y[QW] ? NORM_LIM : $signed({1'b0, q_y[QW]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn        <= neg_x[QW] ? -mag_x : mag_x;
      yn        <= neg_y[QW] ? -mag_y : mag_y;
      side.zero <= zero[QW];
      side.clip <= ovf_x[QW] | ovf_y[QW];
    end
  end

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (xn <= NORM_LIM && xn >= -NORM_LIM && yn <= NORM_LIM && yn >= -NORM_LIM))
    else $error("normalized coordinate out of range");

endmodule

@@ design/cpp_distort.sv @@
module cpp_distort (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [cpp_pkg::NormW-1:0]  xn,
  input  logic signed [cpp_pkg::NormW-1:0]  yn,
  input  cpp_pkg::side_t                    in_side,
  input  logic [cpp_pkg::DistCfgW-1:0]      lens,
  output logic                              out_valid,
  output logic signed [cpp_pkg::DistW-1:0]  xd,
  output logic signed [cpp_pkg::DistW-1:0]  yd,
  output cpp_pkg::side_t                    out_side
);
  import cpp_pkg::*;

  localparam int SqW  = 2 * NormW;
  localparam int R2W  = 27;
  localparam int SmW  = 26;
  localparam int R4W  = 36;
  localparam int R6W  = 45;
  localparam int TW   = 41;
  localparam int PolW = 58;
  localparam int RawW = 51;
  localparam int MW   = NormW + RcW;

  logic signed [CoefW-1:0] k1, k2, k3, p1, p2;

  logic [9:0] v;
  side_t      sd [10];

  logic signed [NormW-1:0] xn1, yn1, xn2, yn2, xn3, yn3, xn4, yn4, xn5, yn5;
  logic signed [NormW-1:0] xn6, yn6, xn7, yn7, xn8, yn8;
  logic signed [SqW-1:0]   xx1, yy1, xy1;
  logic signed [R2W-1:0]   r2_2, r2_3, r2_4;
  logic signed [SmW-1:0]   xx2, yy2, xy2;
  logic signed [2*R2W-1:0] r4p3;
  logic signed [CoefW+SmW-1:0] ta3, td3;
  logic signed [CoefW+R2W:0]   tb3, tc3;
  logic signed [R4W-1:0]   r4_4;
  logic signed [TW-1:0]    tx4, ty4, tx5, ty5, tx6, ty6, tx7, ty7, tx8, ty8, tx9, ty9;
  logic signed [R4W+R2W-1:0] r6p5;
  logic signed [CoefW+R2W-1:0] k1r2_5;
  logic signed [CoefW+R4W-1:0] k2r4_5;
  logic signed [R6W-1:0]   r6_6;
  logic signed [CoefW+R4W:0] s12_6, s12_7;
  logic signed [CoefW+R6W-1:0] k3r6_7;
  logic signed [RcW-1:0]   rc8;
  logic signed [MW-1:0]    mx9, my9;

  logic signed [SqW:0]     r2_sum;
  logic signed [R2W:0]     rx2, ry2;
  logic signed [PolW-1:0]  poly;
  logic signed [RawW-1:0]  rc_raw;
  logic signed [RcW-1:0]   rc_clamp;
  logic                    rc_clip;

  always_comb begin
    k1 = lens[0*CoefW +: CoefW];
    k2 = lens[1*CoefW +: CoefW];
    k3 = lens[2*CoefW +: CoefW];
    p1 = lens[3*CoefW +: CoefW];
    p2 = lens[4*CoefW +: CoefW];
  end

  always_comb begin
    r2_sum = (SqW+1)'(xx1) + (SqW+1)'(yy1) + (SqW+1)'(32768);
    rx2    = (R2W+1)'(r2_2) + (R2W+1)'(xx2) + (R2W+1)'(xx2);
    ry2    = (R2W+1)'(r2_2) + (R2W+1)'(yy2) + (R2W+1)'(yy2);
    poly   = PolW'(s12_7) + PolW'(k3r6_7);
    rc_raw = RawW'((poly + PolW'(128)) >>> 8) + RawW'(65536);
    rc_clip = 1'b0;
    if (rc_raw > RawW'(RC_LIM)) begin
      rc_clamp = RC_LIM;
      rc_clip  = 1'b1;
    end else if (rc_raw < -RawW'(RC_LIM)) begin
      rc_clamp = -RC_LIM;
      rc_clip  = 1'b1;
    end else begin
      rc_clamp = RcW'(rc_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // squares
      xx1 <= xn * xn;
      yy1 <= yn * yn;
      xy1 <= xn * yn;
      xn1 <= xn;
      yn1 <= yn;
      sd[0] <= in_side;
      // rescale to Q.16
      r2_2 <= R2W'(r2_sum >>> 16);
      xx2  <= SmW'((xx1 + SqW'(32768)) >>> 16);
      yy2  <= SmW'((yy1 + SqW'(32768)) >>> 16);
      xy2  <= SmW'((xy1 + SqW'(32768)) >>> 16);
      xn2  <= xn1;
      yn2  <= yn1;
      sd[1] <= sd[0];
      // r2^2 and tangential products
      r4p3 <= r2_2 * r2_2;
      ta3  <= p1 * xy2;
      tb3  <= p2 * rx2;
      tc3  <= p1 * ry2;
      td3  <= p2 * xy2;
      r2_3 <= r2_2;
      xn3  <= xn2;
      yn3  <= yn2;
      sd[2] <= sd[1];
      r4_4 <= R4W'((r4p3 + (2*R2W)'(32768)) >>> 16);
      tx4  <= TW'(ta3) + TW'(ta3) + TW'(tb3);
      ty4  <= TW'(tc3) + TW'(td3) + TW'(td3);
      r2_4 <= r2_3;
      xn4  <= xn3;
      yn4  <= yn3;
      sd[3] <= sd[2];
      r6p5   <= r4_4 * r2_4;
      k1r2_5 <= k1 * r2_4;
      k2r4_5 <= k2 * r4_4;
      tx5 <= tx4;
      ty5 <= ty4;
      xn5 <= xn4;
      yn5 <= yn4;
      sd[4] <= sd[3];
      r6_6  <= R6W'((r6p5 + (R4W+R2W)'(32768)) >>> 16);
      s12_6 <= (CoefW+R4W+1)'(k1r2_5) + (CoefW+R4W+1)'(k2r4_5);
      tx6 <= tx5;
      ty6 <= ty5;
      xn6 <= xn5;
      yn6 <= yn5;
      sd[5] <= sd[4];
      k3r6_7 <= k3 * r6_6;
      s12_7  <= s12_6;
      tx7 <= tx6;
      ty7 <= ty6;
      xn7 <= xn6;
      yn7 <= yn6;
      sd[6] <= sd[5];
      // radial factor
      rc8 <= rc_clamp;
      tx8 <= tx7;
      ty8 <= ty7;
      xn8 <= xn7;
      yn8 <= yn7;
      sd[7].zero <= sd[6].zero;
      sd[7].clip <= sd[6].clip | rc_clip;
      mx9 <= xn8 * rc8;
      my9 <= yn8 * rc8;
      tx9 <= tx8;
      ty9 <= ty8;
      sd[8] <= sd[7];
      xd <= DistW'((mx9 + MW'(32768)) >>> 16) + DistW'((tx9 + TW'(128)) >>> 8);
      yd <= DistW'((my9 + MW'(32768)) >>> 16) + DistW'((ty9 + TW'(128)) >>> 8);
      sd[9] <= sd[8];
    end
  end

  assign out_valid = v[9];
  assign out_side  = sd[9];

endmodule

@@ design/cpp_intrinsics.sv @@
module cpp_intrinsics (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [cpp_pkg::DistW-1:0] xd,
  input  logic signed [cpp_pkg::DistW-1:0] yd,
  input  cpp_pkg::side_t                   in_side,
  input  logic [cpp_pkg::FocalW-1:0]       focal,
  input  logic [cpp_pkg::PrincW-1:0]       princ,
  output logic                             out_valid,
  output cpp_pkg::pixel_t                  pix
);
  import cpp_pkg::*;

  localparam int LoW  = 19;
  localparam int HiW  = DistW - LoW;
  localparam int PpW  = IntrW + LoW + 2;
  localparam int SumW = 60;
  localparam int RawW = 45;

  logic signed [IntrW:0]   fx, fy, cx, cy;
  logic signed [IntrW-1:0] sk;
  logic signed [HiW-1:0]   xh, yh;
  logic signed [LoW:0]     xl, yl;

  logic signed [PpW-1:0]  pfh1, pfl1, psh1, psl1, pyh1, pyl1;
  logic signed [SumW-1:0] su2, sv2;
  side_t                  sd1, sd2;
  logic                   v1, v2;

  logic signed [RawW-1:0] ur, vr;
  logic signed [PixW-1:0] uc, vc;
  logic                   uclip, vclip;

  always_comb begin
    fx = $signed({1'b0, focal[0 +: IntrW]});
    fy = $signed({1'b0, focal[IntrW +: IntrW]});
    cx = $signed({1'b0, princ[0 +: IntrW]});
    cy = $signed({1'b0, princ[IntrW +: IntrW]});
    sk = princ[2*IntrW +: IntrW];
    xh = xd[DistW-1:LoW];
    yh = yd[DistW-1:LoW];
    xl = $signed({1'b0, xd[LoW-1:0]});
    yl = $signed({1'b0, yd[LoW-1:0]});
  end

  always_comb begin
    ur = RawW'((su2 + SumW'(32768)) >>> 16) + RawW'(cx);
    vr = RawW'((sv2 + SumW'(32768)) >>> 16) + RawW'(cy);
    uclip = 1'b0;
    vclip = 1'b0;
    if (ur > RawW'(PIX_MAX)) begin
      uc = PIX_MAX;
      uclip = 1'b1;
    end else if (ur < RawW'(PIX_MIN)) begin
      uc = PIX_MIN;
      uclip = 1'b1;
    end else begin
      uc = PixW'(ur);
    end
    if (vr > RawW'(PIX_MAX)) begin
      vc = PIX_MAX;
      vclip = 1'b1;
    end else if (vr < RawW'(PIX_MIN)) begin
      vc = PIX_MIN;
      vclip = 1'b1;
    end else begin
      vc = PixW'(vr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // split products, high half weighted 2^19
      pfh1 <= fx * xh;
      pfl1 <= fx * xl;
      psh1 <= sk * yh;
      psl1 <= sk * yl;
      pyh1 <= fy * yh;
      pyl1 <= fy * yl;
      sd1  <= in_side;
      su2  <= (SumW'(pfh1) <<< LoW) + SumW'(pfl1) + (SumW'(psh1) <<< LoW) + SumW'(psl1);
      sv2  <= (SumW'(pyh1) <<< LoW) + SumW'(pyl1);
      sd2  <= sd1;
      if (sd2.zero) begin
        pix.image_u    <= '0;
        pix.image_v    <= '0;
        pix.depth_zero <= 1'b1;
        pix.clipped    <= 1'b0;
      end else begin
        pix.image_u    <= uc;
        pix.image_v    <= vc;
        pix.depth_zero <= 1'b0;
        pix.clipped    <= sd2.clip | uclip | vclip;
      end
    end
  end

endmodule

@@ design/camera_point_projection_core.sv @@
// channel  modport  word     fields
// point    sink     world_t  world_x, world_y, world_z (s20)
// pixel    source   pixel_t  image_u, image_v (s24 Q18.6), depth_zero, clipped
// cfg      write    -        cfg_write, cfg_index, cfg_data
//
// One word per clock while pixel is not stalled; 38 register stages.
// Depth set by the normalizing divider: one quotient bit per stage (20 stages).
// Synchronous reset clears the pipeline valids and loads default registers.
// A stall on pixel freezes the whole pipeline; point.ready drops with it.
module camera_point_projection_core (
  input  logic                          clk,
  input  logic                          rst,
  cpp_point_if.sink                     point,
  cpp_pixel_if.source                   pixel,
  input  logic                          cfg_write,
  input  logic [cpp_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [cpp_pkg::CfgW-1:0]      cfg_data
);
  import cpp_pkg::*;

  cfg_t cfg;
  logic en;

  logic                    t_valid;
  logic signed [CamW-1:0]  xc, yc, zc;
  logic                    n_valid;
  logic signed [NormW-1:0] xn, yn;
  side_t                   n_side;
  logic                    d_valid;
  logic signed [DistW-1:0] xd, yd;
  side_t                   d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_x <= ROT_X_RST;
      cfg.rot_y <= ROT_Y_RST;
      cfg.rot_z <= ROT_Z_RST;
      cfg.trans <= '0;
      cfg.lens  <= '0;
      cfg.focal <= FOCAL_RST;
      cfg.princ <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROT_X: cfg.rot_x <= cfg_data[RotW-1:0];
        REG_ROT_Y: cfg.rot_y <= cfg_data[RotW-1:0];
        REG_ROT_Z: cfg.rot_z <= cfg_data[RotW-1:0];
        REG_TRANS: cfg.trans <= cfg_data[TransW-1:0];
        REG_DIST:  cfg.lens  <= cfg_data[DistCfgW-1:0];
        REG_FOCAL: cfg.focal <= cfg_data[FocalW-1:0];
        REG_PRINC: cfg.princ <= cfg_data[PrincW-1:0];
        default: ;
      endcase
    end
  end

  assign en          = !pixel.valid || pixel.ready;
  assign point.ready = en;

  cpp_transform u_transform (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (point.valid),
    .pt        (point.data),
    .cfg       (cfg),
    .out_valid (t_valid),
    .xc        (xc),
    .yc        (yc),
    .zc        (zc)
  );

  cpp_norm_div u_norm_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t_valid),
    .xc        (xc),
    .yc        (yc),
    .zc        (zc),
    .out_valid (n_valid),
    .xn        (xn),
    .yn        (yn),
    .side      (n_side)
  );

  cpp_distort u_distort (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (n_valid),
    .xn        (xn),
    .yn        (yn),
    .in_side   (n_side),
    .lens      (cfg.lens),
    .out_valid (d_valid),
    .xd        (xd),
    .yd        (yd),
    .out_side  (d_side)
  );

  cpp_intrinsics u_intrinsics (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .xd        (xd),
    .yd        (yd),
    .in_side   (d_side),
    .focal     (cfg.focal),
    .princ     (cfg.princ),
    .out_valid (pixel.valid),
    .pix       (pixel.data)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !pixel.valid)
    else $error("pixel valid after reset");

  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.data.depth_zero) |->
      (pixel.data.image_u == '0 && pixel.data.image_v == '0 && !pixel.data.clipped))
    else $error("zero depth word carries nonzero payload");

endmodule

@@ tb/sv/camera_point_projection_core_tb.sv @@
module camera_point_projection_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  cpp_point_if point();
  cpp_pixel_if pixel();

  camera_point_projection_core dut (
    .clk(clk), .rst(rst), .point(point.sink), .pixel(pixel.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("camera_point_projection_core_tb: errors");
    $finish;
  end

  // projection parameters mirrored from register writes
  logic [RotW-1:0] m_rx, m_ry, m_rz;
  logic [TransW-1:0] m_trans;
  logic [DistCfgW-1:0] m_dist;
  logic [FocalW-1:0] m_focal;
  logic [PrincW-1:0] m_princ;

  world_t point_q[$];
  pixel_t pixel_q[$];
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;
  int n_err = 0, n_pix = 0, n_pts = 0, n_clip = 0, n_zero = 0;
  bit pt_taken = 1'b0;

  function automatic longint sx(longint v, int w);
    return (v <<< (64 - w)) >>> (64 - w);
  endfunction

  function automatic longint rnd_shr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint norm_q16(longint a, longint d, ref bit clip);
    longint na, nd, q;
    na = (a < 0) ? -a : a;
    nd = (d < 0) ? -d : d;
    q = ((na <<< 16) + nd / 2) / nd;
    if (q > 1048575) begin
      clip = 1'b1;
      q = 1048575;
    end
    return ((a < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi, ref bit clip);
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint rot_dot(logic [RotW-1:0] r, longint x, longint y,
                                     longint z, longint t);
    return sx(r[17:0], 18) * x + sx(r[35:18], 18) * y + sx(r[53:36], 18) * z
           + t * 65536;
  endfunction

  function automatic pixel_t project(world_t p);
    pixel_t o;
    bit clip;
    longint x, y, z, xc, yc, zc, xn, yn, r2, r4, r6, rc, xx, yy, xy, tx, ty;
    longint xd, yd, u, v, k1, k2, k3, p1, p2;
    clip = 1'b0;
    x = p.world_x;
    y = p.world_y;
    z = p.world_z;
    xc = rot_dot(m_rx, x, y, z, sx(m_trans[19:0], 20));
    yc = rot_dot(m_ry, x, y, z, sx(m_trans[39:20], 20));
    zc = rot_dot(m_rz, x, y, z, sx(m_trans[59:40], 20));
    o = '0;
    if (zc == 0) begin
      o.depth_zero = 1'b1;
      return o;
    end
    k1 = sx(m_dist[11:0], 12);
    k2 = sx(m_dist[23:12], 12);
    k3 = sx(m_dist[35:24], 12);
    p1 = sx(m_dist[47:36], 12);
    p2 = sx(m_dist[59:48], 12);
    xn = norm_q16(xc, zc, clip);
    yn = norm_q16(yc, zc, clip);
    r2 = rnd_shr(xn * xn + yn * yn, 16);
    r4 = rnd_shr(r2 * r2, 16);
    r6 = rnd_shr(r4 * r2, 16);
    rc = sat(65536 + rnd_shr(k1 * r2 + k2 * r4 + k3 * r6, 8),
             -2147483647, 2147483647, clip);
    xx = rnd_shr(xn * xn, 16);
    yy = rnd_shr(yn * yn, 16);
    xy = rnd_shr(xn * yn, 16);
    tx = 2 * p1 * xy + p2 * (r2 + 2 * xx);
    ty = p1 * (r2 + 2 * yy) + 2 * p2 * xy;
    xd = rnd_shr(xn * rc, 16) + rnd_shr(tx, 8);
    yd = rnd_shr(yn * rc, 16) + rnd_shr(ty, 8);
    u = rnd_shr(longint'(m_focal[19:0]) * xd + sx(m_princ[59:40], 20) * yd, 16)
        + longint'(m_princ[19:0]);
    v = rnd_shr(longint'(m_focal[39:20]) * yd, 16) + longint'(m_princ[39:20]);
    u = sat(u, -8388608, 8388607, clip);
    v = sat(v, -8388608, 8388607, clip);
    o.image_u = u[23:0];
    o.image_v = v[23:0];
    o.clipped = clip;
    return o;
  endfunction

  always @(posedge clk) pt_taken <= point.valid && point.ready;

  // driver
  always @(negedge clk) begin
    if (rst) begin
      point.valid <= 1'b0;
      point.data <= '0;
    end else if (!point.valid || pt_taken) begin
      if (point_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        point.valid <= 1'b1;
        point.data <= point_q.pop_front();
      end else begin
        point.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) pixel.ready <= 1'b0;
    else if (hold_off > 0) begin
      pixel.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else pixel.ready <= ($urandom_range(99) >= recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && point.valid && point.ready) begin
      pixel_q.push_back(project(point.data));
      n_pts++;
    end
    if (!rst && pixel.valid && pixel.ready) begin
      n_pix++;
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel word");
        n_err++;
      end else begin
        pixel_t e;
        e = pixel_q.pop_front();
        if (e.image_u !== pixel.data.image_u) begin
          $error("image_u exp %0d got %0d", e.image_u, pixel.data.image_u);
          n_err++;
        end
        if (e.image_v !== pixel.data.image_v) begin
          $error("image_v exp %0d got %0d", e.image_v, pixel.data.image_v);
          n_err++;
        end
        if (e.depth_zero !== pixel.data.depth_zero) begin
          $error("depth_zero exp %0b got %0b", e.depth_zero, pixel.data.depth_zero);
          n_err++;
        end
        if (e.clipped !== pixel.data.clipped) begin
          $error("clipped exp %0b got %0b", e.clipped, pixel.data.clipped);
          n_err++;
        end
        n_clip += e.clipped;
        n_zero += e.depth_zero;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_ROT_X: m_rx = val[RotW-1:0];
      REG_ROT_Y: m_ry = val[RotW-1:0];
      REG_ROT_Z: m_rz = val[RotW-1:0];
      REG_TRANS: m_trans = val[TransW-1:0];
      REG_DIST:  m_dist = val[DistCfgW-1:0];
      REG_FOCAL: m_focal = val[FocalW-1:0];
      default:   m_princ = val[PrincW-1:0];
    endcase
  endtask

  task automatic drain();
    while (point_q.size() > 0 || point.valid || pixel_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [WorldW-1:0] rnd_coord(int mode);
    case (mode)
      0: return WorldW'($urandom);
      1: return WorldW'($urandom_range(200) - 100);
      default: return WorldW'($urandom_range(4000) - 2000);
    endcase
  endfunction

  task automatic add_points(int n);
    world_t p;
    repeat (n) begin
      int m;
      m = $urandom_range(3);
      p.world_x = rnd_coord(m);
      p.world_y = rnd_coord(m);
      p.world_z = (m == 0) ? rnd_coord(0) : 20'($urandom_range(3000) + 1);
      if ($urandom_range(30) == 0) p.world_z = '0;
      point_q.push_back(p);
    end
  endtask

  function automatic logic [CfgW-1:0] pack3(int w, longint a, longint b, longint c);
    logic [CfgW-1:0] r;
    r = '0;
    for (int i = 0; i < w; i++) begin
      r[i] = a[i];
      r[w + i] = b[i];
      r[2 * w + i] = c[i];
    end
    return r;
  endfunction

  task automatic random_cfg();
    write_reg(REG_ROT_X, pack3(18, 65536 + $urandom_range(8000) - 4000,
                               $urandom_range(8000) - 4000, $urandom_range(8000) - 4000));
    write_reg(REG_ROT_Y, pack3(18, $urandom_range(8000) - 4000,
                               65536 + $urandom_range(8000) - 4000, $urandom_range(8000) - 4000));
    write_reg(REG_ROT_Z, pack3(18, $urandom_range(8000) - 4000,
                               $urandom_range(8000) - 4000, 65536));
    write_reg(REG_TRANS, pack3(20, $urandom_range(200) - 100,
                               $urandom_range(200) - 100, $urandom_range(2000)));
    write_reg(REG_DIST, CfgW'({$urandom, $urandom}));
    write_reg(REG_FOCAL, CfgW'({20'($urandom_range(80000)), 20'($urandom_range(80000))}));
    write_reg(REG_PRINC, {20'($urandom_range(2000) - 1000), 20'($urandom_range(40000)),
                          20'($urandom_range(40000))});
  endtask

  initial begin
    world_t p;
    m_rx = ROT_X_RST;
    m_ry = ROT_Y_RST;
    m_rz = ROT_Z_RST;
    m_trans = '0;
    m_dist = '0;
    m_focal = FOCAL_RST;
    m_princ = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, zero depth, negative depth, overflow
    p = '0;
    point_q.push_back(p);
    p = {20'sd1, 20'sd3, 20'sd5};
    point_q.push_back(p);
    p = {-20'sd7, 20'sd3, -20'sd5};
    point_q.push_back(p);
    p = {20'sd1, 20'sd524287, -20'sd524288};
    point_q.push_back(p);
    p = {-20'sd524288, -20'sd524288, -20'sd524288};
    point_q.push_back(p);
    p = {20'sd524287, 20'sd524287, 20'sd524287};
    point_q.push_back(p);
    p = {20'sd0, 20'sd10, 20'sd10};
    point_q.push_back(p);
    drain();

    write_reg(REG_DIST, {12'h7ff, 12'h800, 12'h7ff, 12'h800, 12'h7ff});
    write_reg(REG_FOCAL, CfgW'(40'hfffff_fffff));
    write_reg(REG_PRINC, 60'h80000_fffff_fffff);
    p = {20'sd1, 20'sd1000, -20'sd1000};
    point_q.push_back(p);
    p = {20'sd1, -20'sd3, 20'sd2};
    point_q.push_back(p);
    p = {20'sd1000, 20'sd0, 20'sd0};
    point_q.push_back(p);
    add_points(8);
    drain();

    write_reg(REG_ROT_X, CfgW'({18'h3ffff, 18'h3ffff, 18'h3ffff}));
    write_reg(REG_ROT_Y, CfgW'({18'h20000, 18'h1ffff, 18'h20000}));
    write_reg(REG_ROT_Z, CfgW'({18'h1ffff, 18'h20000, 18'h1ffff}));
    write_reg(REG_TRANS, {20'h80000, 20'h7ffff, 20'h80000});
    write_reg(REG_DIST, '0);
    write_reg(REG_FOCAL, '0);
    write_reg(REG_PRINC, '0);
    add_points(5);
    drain();

    send_idle = 8;
    recv_idle = 53;
    random_cfg();
    add_points(200);
    drain();

    // backpressure: long receiver stall while points keep coming
    hold_off <= 300;
    add_points(100);
    drain();

    send_idle = 53;
    recv_idle = 8;
    random_cfg();
    add_points(150);
    drain();

    send_idle = 0;
    recv_idle = 0;
    random_cfg();
    add_points(150);
    drain();

    $display("covered %0d points, %0d pixels (%0d clipped, %0d zero depth)",
             n_pts, n_pix, n_clip, n_zero);
    if (n_err == 0 && pixel_q.size() == 0) begin
      $display("camera_point_projection_core_tb: clean");
    end else begin
      $display("camera_point_projection_core_tb: errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/cpp_pkg.sv
design/cpp_if.sv
design/cpp_transform.sv
design/cpp_norm_div.sv
design/cpp_distort.sv
design/cpp_intrinsics.sv
design/camera_point_projection_core.sv
tb/sv/camera_point_projection_core_tb.sv
